// ----- sv/tilt_gesture_detector_assert.svh -----
// Assertion macros used by the tilt gesture detector top file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TILT_GESTURE_DETECTOR_ASSERT_SVH
`define TILT_GESTURE_DETECTOR_ASSERT_SVH

// Whenever the condition holds, the consequence holds in the same cycle.
`define TGD_ASSERT_IMPLY(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("tilt gesture detector: same-cycle check failed");

// Whenever the condition holds, the consequence holds in the next cycle.
`define TGD_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("tilt gesture detector: next-cycle check failed");

`endif

// ----- sv/tgd_pkg.sv -----
`timescale 1ns / 1ps

package tgd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_WEIGHT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TILT_THRESH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_LIMIT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF_MS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_NEEDED = 3'd4;

    localparam logic [8:0]  FILTER_WEIGHT_RST = 9'd51;
    localparam logic [13:0] TILT_THRESH_RST   = 14'd1920;
    localparam logic [15:0] LIGHT_LIMIT_RST   = 16'd300;
    localparam logic [15:0] HOLDOFF_MS_RST    = 16'd500;
    localparam logic [2:0]  REPEAT_NEEDED_RST = 3'd3;

    // Roll is wrapped once into plus or minus 180 degrees at 1/64 degree.
    localparam logic signed [16:0] ROLL_WRAP_LIMIT = 17'sd11520;
    localparam logic signed [16:0] ROLL_WRAP_SPAN  = 17'sd23040;

    localparam int             WEIGHT_FRAC  = 8;
    localparam logic [8:0]     FULL_WEIGHT  = 9'd256;
    localparam logic signed [24:0] ROUND_HALF = 25'sd128;

    localparam logic [2:0] RUN_MAX  = 3'd7;
    localparam logic [2:0] RUN_ONE  = 3'd1;
    localparam logic [2:0] RUN_ZERO = 3'd0;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } dir_t;

    typedef struct packed {
        logic [8:0]  filter_weight;
        logic [13:0] tilt_thresh;
        logic [15:0] light_limit;
        logic [15:0] holdoff_ms;
        logic [2:0]  repeat_needed;
    } cfg_t;

    typedef struct packed {
        logic [31:0] last_fire_time;
        logic        ever_fired;
        logic [2:0]  run_length;
        logic        armed_fired;
        dir_t        run_direction;
    } gest_state_t;

endpackage

// ----- sv/tgd_gesture.sv -----
`timescale 1ns / 1ps

module tgd_gesture
(
    input  tgd_pkg::cfg_t         cfg,
    input  tgd_pkg::gest_state_t  state_cur,
    input  logic signed [14:0]    roll,
    input  logic signed [14:0]    filt_cur,
    input  logic [15:0]           light,
    input  logic [31:0]           now,
    output logic signed [14:0]    filt_new,
    output tgd_pkg::gest_state_t  state_new,
    output tgd_pkg::dir_t         code
);
    import tgd_pkg::*;

    logic [8:0]         weight;
    logic [8:0]         weight_old;
    logic signed [24:0] prod_new;
    logic signed [24:0] prod_old;
    logic signed [24:0] acc;
    logic signed [24:0] acc_shift;
    logic               hold_ok;
    logic signed [15:0] trig;
    logic signed [15:0] filt_ext;
    logic [14:0]        mag;
    logic [15:0]        mag2;
    logic [2:0]         need;
    dir_t               dir;

    always_comb
    begin
        weight     = (cfg.filter_weight > FULL_WEIGHT) ? FULL_WEIGHT : cfg.filter_weight;
        weight_old = FULL_WEIGHT - weight;
        prod_new   = $signed({16'd0, weight}) * $signed({{10{roll[14]}}, roll});
        prod_old   = $signed({16'd0, weight_old}) * $signed({{10{filt_cur[14]}}, filt_cur});
        acc        = prod_new + prod_old + ROUND_HALF;
        acc_shift  = acc >>> WEIGHT_FRAC;
        filt_new   = acc_shift[14:0];
    end

    always_comb
    begin
        hold_ok  = !state_cur.ever_fired
                   || ((now - state_cur.last_fire_time) >= {16'd0, cfg.holdoff_ms});
        trig     = $signed({2'b00, cfg.tilt_thresh});
        filt_ext = {filt_new[14], filt_new};
        mag      = filt_new[14] ? 15'(-filt_new) : 15'(filt_new);
        mag2     = {mag, 1'b0};
        need     = (cfg.repeat_needed == RUN_ZERO) ? RUN_ONE : cfg.repeat_needed;

        if (filt_ext > trig)
        begin
            dir = DIR_POS;
        end
        else if (filt_ext < -trig)
        begin
            dir = DIR_NEG;
        end
        else
        begin
            dir = DIR_NONE;
        end

        state_new = state_cur;
        code      = DIR_NONE;

        // Inside the hold-off window the run state is frozen.
        if (hold_ok)
        begin
            if (light < cfg.light_limit)
            begin
                if (dir != DIR_NONE)
                begin
                    if (!state_cur.armed_fired)
                    begin
                        if (dir == state_cur.run_direction)
                        begin
                            if (state_cur.run_length != RUN_MAX)
                            begin
                                state_new.run_length = state_cur.run_length + RUN_ONE;
                            end
                        end
                        else
                        begin
                            state_new.run_length    = RUN_ONE;
                            state_new.run_direction = dir;
                        end
                        if (state_new.run_length >= need)
                        begin
                            code                     = dir;
                            state_new.last_fire_time = now;
                            state_new.ever_fired     = 1'b1;
                            state_new.run_length     = RUN_ZERO;
                            state_new.armed_fired    = 1'b1;
                        end
                    end
                end
                else if (mag2 < $unsigned(trig))
                begin
                    state_new.run_length    = RUN_ZERO;
                    state_new.armed_fired   = 1'b0;
                    state_new.run_direction = DIR_NONE;
                end
            end
            else
            begin
                state_new.run_length    = RUN_ZERO;
                state_new.armed_fired   = 1'b0;
                state_new.run_direction = DIR_NONE;
            end
        end
    end

endmodule

// ----- sv/tilt_gesture_detector.sv -----
`timescale 1ns / 1ps
// Channel    Direction  Handshake                      Contents
// s_axis     in         s_axis_tvalid / s_axis_tready  roll, light level, time stamp
// m_axis     out        m_axis_tvalid / m_axis_tready  filtered roll, gesture, valid flag
// cfg        in         cfg_valid / cfg_ready          register index and write data
//
// Each item passes an input register and a result register.
// One item is accepted every cycle while the result side keeps taking results.
// A stalled result holds the result register; the input register still takes one item.
// Reset empties the input and result registers and clears the calibration and the gesture state.
// Configuration writes are taken in every cycle.

module tilt_gesture_detector
#(
    parameter int CALIB_SAMPLES = 5
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // roll_in [15:0], light_level [31:16], time_ms [63:32]
    input  logic [63:0]                       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // smooth_roll [14:0], gesture_code [16:15], zeros above
    output logic [23:0]                       m_axis_tdata,
    // filtered_valid [0]
    output logic [0:0]                        m_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tgd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tgd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tgd_pkg::*;

    localparam int CNT_W     = $clog2(CALIB_SAMPLES + 1);
    localparam int SUM_W     = 15 + $clog2(CALIB_SAMPLES);
    localparam int MAG_W     = SUM_W - 1;
    localparam int DIV_SHIFT = MAG_W + 5;
    localparam int DIV_MW    = DIV_SHIFT + 1;
    localparam int PROD_W    = MAG_W + DIV_MW;
    localparam logic [DIV_MW-1:0] DIV_MULT =
        DIV_MW'(((2 ** DIV_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES);
    localparam logic [CNT_W-1:0] CALIB_DONE = CNT_W'(CALIB_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

    cfg_t               cfg_reg;

    logic               in_valid_reg;
    logic signed [15:0] in_roll_reg;
    logic [15:0]        in_light_reg;
    logic [31:0]        in_time_reg;

    logic [CNT_W-1:0]       calib_count_reg, calib_count_next;
    logic signed [SUM_W-1:0] calib_sum_reg, calib_sum_next;
    logic signed [14:0]     filter_value_reg, filter_value_next;
    gest_state_t            gest_reg, gest_next;

    logic               out_valid_reg;
    logic signed [14:0] res_roll_reg, res_roll_next;
    logic               res_flag_reg, res_flag_next;
    dir_t               res_code_reg, res_code_next;

    logic               in_accept;
    logic               advance;
    logic signed [16:0] roll_ext;
    logic signed [16:0] roll_wrap;
    logic signed [14:0] roll;
    logic               calibrating;
    logic               sum_neg;
    logic [MAG_W-1:0]   sum_mag;
    logic [PROD_W-1:0]  div_prod;
    logic [14:0]        avg_mag;
    logic signed [14:0] avg;
    logic signed [14:0] filt_new;
    gest_state_t        gest_new;
    dir_t               code_new;
    logic               fire_take;
    logic               fire_seen;
    logic               res_zero;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_weight <= FILTER_WEIGHT_RST;
            cfg_reg.tilt_thresh   <= TILT_THRESH_RST;
            cfg_reg.light_limit   <= LIGHT_LIMIT_RST;
            cfg_reg.holdoff_ms    <= HOLDOFF_MS_RST;
            cfg_reg.repeat_needed <= REPEAT_NEEDED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FILTER_WEIGHT: cfg_reg.filter_weight <= cfg_data[8:0];
                REG_TILT_THRESH:   cfg_reg.tilt_thresh   <= cfg_data[13:0];
                REG_LIGHT_LIMIT:   cfg_reg.light_limit   <= cfg_data;
                REG_HOLDOFF_MS:    cfg_reg.holdoff_ms    <= cfg_data;
                REG_REPEAT_NEEDED: cfg_reg.repeat_needed <= cfg_data[2:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_roll_reg  <= $signed(s_axis_tdata[15:0]);
            in_light_reg <= s_axis_tdata[31:16];
            in_time_reg  <= s_axis_tdata[63:32];
        end
    end

    always_comb
    begin
        roll_ext = {in_roll_reg[15], in_roll_reg};
        if (roll_ext > ROLL_WRAP_LIMIT)
        begin
            roll_wrap = roll_ext - ROLL_WRAP_SPAN;
        end
        else if (roll_ext < -ROLL_WRAP_LIMIT)
        begin
            roll_wrap = roll_ext + ROLL_WRAP_SPAN;
        end
        else
        begin
            roll_wrap = roll_ext;
        end
        roll = roll_wrap[14:0];
    end

    tgd_gesture u_gesture
    (
        .cfg       (cfg_reg),
        .state_cur (gest_reg),
        .roll      (roll),
        .filt_cur  (filter_value_reg),
        .light     (in_light_reg),
        .now       (in_time_reg),
        .filt_new  (filt_new),
        .state_new (gest_new),
        .code      (code_new)
    );

    // The seed is the calibration sum divided by the sample count, truncated toward
    // zero, done as a multiplication by a rounded-up reciprocal on the magnitude.
    always_comb
    begin
        calibrating    = calib_count_reg < CALIB_DONE;
        calib_sum_next = calib_sum_reg + SUM_W'(roll);
        sum_neg        = calib_sum_next[SUM_W-1];
        sum_mag        = sum_neg ? MAG_W'(-calib_sum_next) : MAG_W'(calib_sum_next);
        div_prod       = PROD_W'(sum_mag) * PROD_W'(DIV_MULT);
        avg_mag        = 15'(div_prod >> DIV_SHIFT);
        avg            = sum_neg ? $signed(-avg_mag) : $signed(avg_mag);

        calib_count_next  = calib_count_reg;
        filter_value_next = filter_value_reg;
        gest_next         = gest_reg;
        res_roll_next     = 15'sd0;
        res_flag_next     = 1'b0;
        res_code_next     = DIR_NONE;

        if (calibrating)
        begin
            calib_count_next = calib_count_reg + CNT_ONE;
            if (calib_count_next == CALIB_DONE)
            begin
                filter_value_next = avg;
            end
        end
        else
        begin
            calib_sum_next    = calib_sum_reg;
            filter_value_next = filt_new;
            gest_next         = gest_new;
            res_roll_next     = filt_new;
            res_flag_next     = 1'b1;
            res_code_next     = code_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_count_reg  <= '0;
            calib_sum_reg    <= '0;
            filter_value_reg <= '0;
            gest_reg         <= '{last_fire_time: 32'd0, ever_fired: 1'b0,
                                  run_length: RUN_ZERO, armed_fired: 1'b0,
                                  run_direction: DIR_NONE};
        end
        else if (advance)
        begin
            calib_count_reg  <= calib_count_next;
            calib_sum_reg    <= calib_sum_next;
            filter_value_reg <= filter_value_next;
            gest_reg         <= gest_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_roll_reg <= res_roll_next;
            res_flag_reg <= res_flag_next;
            res_code_reg <= res_code_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {7'd0, res_code_reg, res_roll_reg};
    assign m_axis_tuser[0] = res_flag_reg;

    assign fire_take = advance && !calibrating && (code_new != DIR_NONE);
    assign fire_seen = gest_reg.ever_fired && gest_reg.armed_fired;
    assign res_zero  = (res_roll_reg == 15'sd0) && (res_code_reg == DIR_NONE);

`include "tilt_gesture_detector_assert.svh"

    `TGD_ASSERT_IMPLY(a_code_needs_filter, out_valid_reg && (res_code_reg != DIR_NONE), res_flag_reg)
    `TGD_ASSERT_IMPLY(a_calib_result_zero, out_valid_reg && !res_flag_reg, res_zero)
    `TGD_ASSERT_NEXT(a_fire_marks_ever, fire_take, fire_seen && (gest_reg.last_fire_time == $past(in_time_reg)))
    `TGD_ASSERT_IMPLY(a_armed_after_fire, gest_reg.armed_fired, gest_reg.ever_fired)
    `TGD_ASSERT_IMPLY(a_calib_count_bound, 1'b1, calib_count_reg <= CALIB_DONE)

endmodule

// ----- tb/sv/tb_tilt_gesture_detector.sv -----
`timescale 1ns / 1ps

module tb_tilt_gesture_detector;
    import tgd_pkg::*;

    localparam int CALIB_COUNT   = 5;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 190;
    localparam int GAP_MAX       = 19;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = REG_REPEAT_NEEDED + 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = {CFG_INDEX_W{1'b1}};

    typedef struct packed {
        logic [31:0]        stamp;
        logic [15:0]        light;
        logic signed [15:0] roll;
    } sample_t;

    typedef struct packed {
        logic signed [14:0] roll;
        dir_t               gesture;
        logic               valid;
    } tilt_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [63:0]            s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [23:0]            m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    sample_t      sample_q[$];
    tilt_result_t roll_gesture_q[$];

    int  items_queued   = 0;
    int  items_accepted = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  send_gap       = 0;
    int  recv_stall     = 0;
    int  send_gap_max   = GAP_MAX;
    int  recv_stall_max = GAP_MAX;
    bit  sample_taken   = 1'b0;
    bit  cfg_taken      = 1'b0;
    logic [31:0] stamp_ms = '0;

    logic [8:0]  w_weight  = FILTER_WEIGHT_RST;
    logic [13:0] w_trigger = TILT_THRESH_RST;
    logic [15:0] w_light   = LIGHT_LIMIT_RST;
    logic [15:0] w_holdoff = HOLDOFF_MS_RST;
    logic [2:0]  w_repeat  = REPEAT_NEEDED_RST;

    int          calib_n   = 0;
    int          calib_acc = 0;
    int          smooth    = 0;
    logic [31:0] fire_stamp = '0;
    bit          has_fired = 1'b0;
    bit          locked    = 1'b0;
    int          run_n     = 0;
    dir_t        run_dir   = DIR_NONE;

    tilt_gesture_detector #(
        .CALIB_SAMPLES(CALIB_COUNT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void clear_tilt_run();
        run_n = 0;
        locked = 1'b0;
        run_dir = DIR_NONE;
    endfunction

    function automatic tilt_result_t filter_and_detect(input sample_t s);
        int           roll;
        int           w;
        int           acc;
        int           trig;
        int           mag;
        int           need;
        logic [31:0]  elapsed;
        dir_t         dir;
        dir_t         code;
        tilt_result_t r;
        roll = int'($signed(s.roll));
        code = DIR_NONE;
        r.roll = '0;
        r.valid = 1'b0;
        r.gesture = DIR_NONE;
        if (roll > int'(ROLL_WRAP_LIMIT))
            roll -= int'(ROLL_WRAP_SPAN);
        else if (roll < -int'(ROLL_WRAP_LIMIT))
            roll += int'(ROLL_WRAP_SPAN);
        if (calib_n < CALIB_COUNT)
        begin
            calib_acc += roll;
            calib_n++;
            if (calib_n == CALIB_COUNT)
                smooth = calib_acc / CALIB_COUNT;
            return r;
        end
        w = (w_weight > FULL_WEIGHT) ? int'(FULL_WEIGHT) : int'(w_weight);
        acc = w * roll + (int'(FULL_WEIGHT) - w) * smooth + int'(ROUND_HALF);
        smooth = acc >>> WEIGHT_FRAC;
        elapsed = s.stamp - fire_stamp;
        if (!has_fired || elapsed >= {16'd0, w_holdoff})
        begin
            if (s.light < w_light)
            begin
                trig = int'(w_trigger);
                dir = DIR_NONE;
                if (smooth > trig)
                    dir = DIR_POS;
                else if (smooth < -trig)
                    dir = DIR_NEG;
                if (dir != DIR_NONE)
                begin
                    if (!locked)
                    begin
                        need = (w_repeat == RUN_ZERO) ? 1 : int'(w_repeat);
                        if (dir == run_dir)
                        begin
                            if (run_n < int'(RUN_MAX))
                                run_n++;
                        end
                        else
                        begin
                            run_n = 1;
                            run_dir = dir;
                        end
                        if (run_n >= need)
                        begin
                            code = dir;
                            fire_stamp = s.stamp;
                            has_fired = 1'b1;
                            run_n = 0;
                            locked = 1'b1;
                        end
                    end
                end
                else
                begin
                    mag = (smooth < 0) ? -smooth : smooth;
                    if (2 * mag < trig)
                        clear_tilt_run();
                end
            end
            else
                clear_tilt_run();
        end
        r.roll = smooth[14:0];
        r.valid = 1'b1;
        r.gesture = code;
        return r;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || sample_taken))
        begin
            sample_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (sample_q.size() > 0)
            begin
                s_axis_tdata <= sample_q.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap = $urandom_range(0, send_gap_max);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (recv_stall > 0)
        begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n;
    end

    always @(posedge clk)
    begin
        tilt_result_t       want;
        logic signed [14:0] got_roll;
        logic [1:0]         got_gesture;
        logic               got_valid;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FILTER_WEIGHT: w_weight  = cfg_data[8:0];
                    REG_TILT_THRESH:   w_trigger = cfg_data[13:0];
                    REG_LIGHT_LIMIT:   w_light   = cfg_data[15:0];
                    REG_HOLDOFF_MS:    w_holdoff = cfg_data[15:0];
                    REG_REPEAT_NEEDED: w_repeat  = cfg_data[2:0];
                    default: ;
                endcase
                cfg_taken = 1'b1;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                roll_gesture_q.push_back(filter_and_detect(sample_t'(s_axis_tdata)));
                items_accepted++;
                sample_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_roll = m_axis_tdata[14:0];
                got_gesture = m_axis_tdata[16:15];
                got_valid = m_axis_tuser[0];
                if (roll_gesture_q.size() == 0)
                begin
                    $error("unexpected result: smooth_roll %0d, gesture_code %0d",
                           got_roll, got_gesture);
                    mismatch_count++;
                end
                else
                begin
                    want = roll_gesture_q.pop_front();
                    if (got_roll !== want.roll)
                    begin
                        $error("smooth_roll: expected %0d, actual %0d",
                               $signed(want.roll), got_roll);
                        mismatch_count++;
                    end
                    if (got_valid !== want.valid)
                    begin
                        $error("filtered_valid: expected %0d, actual %0d",
                               want.valid, got_valid);
                        mismatch_count++;
                    end
                    if (got_gesture !== want.gesture)
                    begin
                        $error("gesture_code: expected %0d, actual %0d",
                               want.gesture, got_gesture);
                        mismatch_count++;
                    end
                end
                recv_stall = $urandom_range(0, recv_stall_max);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_sample(input int roll, input int light, input logic [31:0] stamp);
        sample_t s;
        s.roll = roll[15:0];
        s.light = light[15:0];
        s.stamp = stamp;
        sample_q.push_back(s);
        items_queued++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        cfg_taken = 1'b0;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(input int wt, input int tg, input int lt, input int hd,
                                  input int rp);
        write_reg(REG_FILTER_WEIGHT, wt[15:0]);
        write_reg(REG_TILT_THRESH, tg[15:0]);
        write_reg(REG_LIGHT_LIMIT, lt[15:0]);
        write_reg(REG_HOLDOFF_MS, hd[15:0]);
        write_reg(REG_REPEAT_NEEDED, rp[15:0]);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (items_accepted != items_queued || roll_gesture_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic int dim_light();
        if (w_light == '0)
            return 0;
        return $urandom_range(0, int'(w_light) - 1);
    endfunction

    task automatic advance_stamp();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            stamp_ms += $urandom();
        else if (pick == 1)
            stamp_ms += $urandom_range(200, 70000);
        else
            stamp_ms += $urandom_range(0, 150);
    endtask

    task automatic push_tilt_burst();
        int len;
        int amp;
        int k;
        int roll;
        int light;
        bit neg;
        neg = ($urandom_range(0, 1) == 1);
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++)
        begin
            amp = int'(w_trigger) + $urandom_range(1, 4000);
            if (amp > int'(ROLL_WRAP_LIMIT))
                amp = int'(ROLL_WRAP_LIMIT) - $urandom_range(0, 500);
            roll = neg ? -amp : amp;
            light = ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 65535)) : dim_light();
            advance_stamp();
            push_sample(roll, light, stamp_ms);
        end
        len = $urandom_range(0, 10);
        for (k = 0; k < len; k++)
        begin
            roll = $urandom_range(0, int'(w_trigger) / 2 + 1);
            if ($urandom_range(0, 1) == 1)
                roll = -roll;
            advance_stamp();
            push_sample(roll, dim_light(), stamp_ms);
        end
    endtask

    task automatic push_jitter();
        int len;
        int k;
        int roll;
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++)
        begin
            roll = $urandom_range(0, int'(ROLL_WRAP_LIMIT));
            if ((k % 2 == 1) ^ ($urandom_range(0, 3) == 0))
                roll = -roll;
            advance_stamp();
            push_sample(roll, ($urandom_range(0, 1) == 1) ? dim_light()
                                                          : int'($urandom_range(0, 65535)),
                        stamp_ms);
        end
    endtask

    initial
    begin
        int ph;
        int pick;
        int target;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Calibration with wrapped extremes and an average truncated toward zero.
        push_sample(32767, 0, 32'h0000_0000);
        push_sample(-32768, 65535, 32'hFFFF_FFFF);
        push_sample(11521, 1, 32'h0000_0000);
        push_sample(-11521, 299, 32'h0000_0001);
        push_sample(-11520, 300, 32'h0000_0002);
        // First gesture well inside the hold-off time, then frozen detection.
        push_sample(-11520, 0, 32'h0000_0003);
        push_sample(-11520, 0, 32'h0000_0004);
        push_sample(-11520, 0, 32'h0000_0005);
        push_sample(-11520, 0, 32'h0000_0006);
        push_sample(0, 65535, 32'h0000_0007);
        wait_idle();
        write_reg(REG_FILTER_WEIGHT, 16'd256);
        push_sample(0, 0, 32'h0000_0258);
        push_sample(11520, 299, 32'h0000_0259);
        push_sample(11520, 299, 32'h0000_025A);
        push_sample(11520, 299, 32'h0000_025B);
        // Just past the trigger, on it, just under half of it, then light at the limit.
        push_sample(1921, 0, 32'h0000_04B0);
        push_sample(1920, 0, 32'h0000_04B1);
        push_sample(959, 0, 32'h0000_04B2);
        push_sample(-1921, 300, 32'h0000_04B3);
        push_sample(23040, 0, 32'h0000_04B4);
        // A gesture just before the time stamp wraps, then a sample after the wrap.
        push_sample(-23040, 0, 32'hFFFF_FF00);
        push_sample(-11520, 0, 32'hFFFF_FF01);
        push_sample(-11520, 0, 32'hFFFF_FF02);
        push_sample(-11520, 0, 32'hFFFF_FF03);
        push_sample(0, 0, 32'h0000_0100);
        wait_idle();

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:
                begin
                    set_thresholds(256, 0, 65535, 0, 1);
                    send_gap_max = GAP_MAX;
                    recv_stall_max = GAP_MAX;
                end
                1:
                begin
                    set_thresholds(0, 11520, 65535, 65535, 7);
                    send_gap_max = 0;
                    recv_stall_max = 0;
                end
                2:
                begin
                    set_thresholds(511, 16383, 0, 500, 0);
                    stamp_ms = 32'hFFFF_F000;
                    send_gap_max = GAP_MAX;
                    recv_stall_max = 0;
                end
                3:
                begin
                    set_thresholds(128, 640, 1000, 100, 2);
                    send_gap_max = 0;
                    recv_stall_max = GAP_MAX;
                end
                default:
                begin
                    set_thresholds($urandom_range(0, 511), $urandom_range(0, 6000),
                                   $urandom_range(0, 65535), $urandom_range(0, 2000),
                                   $urandom_range(0, 7));
                    write_reg(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                              16'($urandom_range(0, 65535)));
                    send_gap_max = GAP_MAX;
                    recv_stall_max = GAP_MAX;
                end
            endcase
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    push_tilt_burst();
                else if (pick < 9)
                    push_sample($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom());
                else
                    push_jitter();
            end
            wait_idle();
        end

        if (mismatch_count == 0 && roll_gesture_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/tgd_pkg.sv
sv/tgd_gesture.sv
sv/tilt_gesture_detector.sv
tb/sv/tb_tilt_gesture_detector.sv
